// File: sv/nuht_pkg.sv
package nuht_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int HANDLE_W    = 32;
  localparam int VAR_W       = 16;
  localparam int HASH_W      = HANDLE_W + 2;   // (h>>2)+(l<<1) and h+(l<<1)
  localparam int PROBE_W     = ADDR_W + 3;     // 5*pos + step < 6*depth
  localparam int SCAN_W      = 8;
  localparam int NPROBE_W    = SCAN_W + 1;
  localparam int STATUS_W    = 3;

  localparam logic [1:0] REQ_FIND  = 2'd0;
  localparam logic [1:0] REQ_DEL   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_MAX_SCAN   = 1'b1;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef struct packed {
    logic [VAR_W-1:0]    nvar;
    logic [HANDLE_W-1:0] high;
    logic [HANDLE_W-1:0] low;
    logic [HANDLE_W-1:0] handle;
  } slot_data_t;

  typedef struct packed {
    logic              mark_en;
    logic              data_en;
    logic [ADDR_W-1:0] addr;
    mark_t             mark;
  } store_wr_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_STEP,
    S_RD,
    S_CHK,
    S_NEXT,
    S_WTOMB
  } state_t;

endpackage

// File: sv/nuht_mod.sv
// Bit-serial restoring remainder: one dividend bit per cycle.
module nuht_mod import nuht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              short_mode,
  input  logic [HASH_W-1:0] value,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [ADDR_W-1:0] rem
);

  localparam int CNT_W = $clog2(HASH_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [HASH_W-1:0] sh_r;
  logic [ADDR_W-1:0] rem_r;
  logic [SIZE_W-1:0] trial;

  assign trial = {rem_r, sh_r[HASH_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= short_mode ? CNT_W'(PROBE_W) : CNT_W'(HASH_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= short_mode ? (value << (HASH_W - PROBE_W)) : value;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r <= {sh_r[HASH_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_r <= ADDR_W'(trial - divisor);
      end else begin
        rem_r <= trial[ADDR_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: sv/nuht_store.sv
// Slot store: mark array and key/handle array, one write and one read port.
module nuht_store import nuht_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  slot_data_t        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output mark_t             rd_mark,
  output slot_data_t        rd_data
);

  mark_t      mark_mem [TABLE_DEPTH];
  slot_data_t data_mem [TABLE_DEPTH];
  mark_t      rd_mark_r;
  slot_data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.mark_en) begin
      mark_mem[wr.addr] <= wr.mark;
    end
    if (wr.data_en) begin
      data_mem[wr.addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_mark_r <= mark_mem[rd_addr];
      rd_data_r <= data_mem[rd_addr];
    end
  end

  assign rd_mark = rd_mark_r;
  assign rd_data = rd_data_r;

endmodule

// File: sv/node_unique_hash_table.sv
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+------------------------------
// request  | start, busy, in_*                       | start && !busy
// result   | out_valid, out_*                        | out_valid, one cycle
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// A find-or-delete runs the shared serial remainder unit for the home slot
// and again for the probe step, then each probe takes a read, a check and
// a short-mode remainder; busy also covers the tombstone write of the old
// slot when a match moves. Clear sweeps all 4096 marks, one a cycle; the
// same sweep runs after reset with busy high. Results cannot be stalled:
// each is a pulse.
module node_unique_hash_table import nuht_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_req_type,
  input  logic [VAR_W-1:0]    in_node_var,
  input  logic [HANDLE_W-1:0] in_high_ref,
  input  logic [HANDLE_W-1:0] in_low_ref,
  input  logic [HANDLE_W-1:0] in_node_handle,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic [ADDR_W-1:0]   out_slot_pos,
  output logic [SIZE_W-1:0]   out_live_count,
  output logic [NPROBE_W-1:0] out_probes_used,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data
);

  state_t state_r, state_nxt;

  // request latches
  logic [1:0]          req_r;
  slot_data_t          key_r;

  // probe state
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]   step_r, step_nxt;
  logic [ADDR_W-1:0]   tomb_r, tomb_nxt;
  logic                tomb_seen_r, tomb_seen_nxt;
  logic [NPROBE_W-1:0] n_r, n_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                clr_emit_r, clr_emit_nxt;
  logic [SIZE_W-1:0]   live_r, live_nxt;

  // configuration
  logic [SIZE_W-1:0]   size_r;
  logic [SCAN_W-1:0]   scan_r;

  // result registers
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [ADDR_W-1:0]   out_pos_r, out_pos_nxt;
  logic [NPROBE_W-1:0] out_probes_r, out_probes_nxt;

  // shared remainder unit and store
  logic                mod_start, mod_short, mod_done;
  logic [HASH_W-1:0]   mod_value;
  logic [ADDR_W-1:0]   mod_rem;
  logic [SIZE_W-1:0]   eff_size;
  logic [NPROBE_W-1:0] limit;
  logic                accept;
  store_wr_t           wr;
  slot_data_t          wr_data;
  logic                rd_en;
  mark_t               rd_mark;
  slot_data_t          rd_data;
  logic                key_hit;
  logic [PROBE_W-1:0]  probe_sum;

  // Size 0 acts as 1, anything above the depth acts as the depth.
  always_comb begin
    if (size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_r > SIZE_W'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = size_r;
    end
  end

  assign limit     = {1'b0, scan_r} + NPROBE_W'(1);
  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign key_hit   = (rd_mark == MARK_LIVE) && (rd_data.nvar == key_r.nvar) &&
                     (rd_data.high == key_r.high) && (rd_data.low == key_r.low);
  assign probe_sum = (PROBE_W'(pos_r) << 2) + PROBE_W'(pos_r) + PROBE_W'(step_r);

  nuht_mod u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mod_start),
    .short_mode (mod_short),
    .value      (mod_value),
    .divisor    (eff_size),
    .done       (mod_done),
    .rem        (mod_rem)
  );

  nuht_store u_store (
    .clk     (clk),
    .wr      (wr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_mark (rd_mark),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(TABLE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (in_req_type == REQ_FIND || in_req_type == REQ_DEL) begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH:  if (mod_done) state_nxt = S_STEP;
      S_STEP:  if (mod_done) state_nxt = S_RD;
      S_RD:    state_nxt = S_CHK;
      S_CHK: begin
        if (req_r == REQ_FIND) begin
          if (rd_mark == MARK_EMPTY) begin
            state_nxt = S_IDLE;
          end else if (key_hit) begin
            state_nxt = tomb_seen_r ? S_WTOMB : S_IDLE;
          end else if (n_r >= limit) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          if (rd_mark == MARK_EMPTY || key_hit || n_r >= limit) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT:  if (mod_done) state_nxt = S_RD;
      S_WTOMB: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    tomb_nxt       = tomb_r;
    tomb_seen_nxt  = tomb_seen_r;
    n_nxt          = n_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_emit_nxt   = clr_emit_r;
    live_nxt       = live_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_pos_nxt    = out_pos_r;
    out_probes_nxt = out_probes_r;
    mod_start      = 1'b0;
    mod_short      = 1'b0;
    mod_value      = '0;
    rd_en          = 1'b0;
    wr             = '{mark_en: 1'b0, data_en: 1'b0, addr: pos_r, mark: MARK_EMPTY};
    wr_data        = key_r;
    case (state_r)
      S_CLEAR: begin
        wr.mark_en  = 1'b1;
        wr.addr     = clr_cnt_r;
        wr.mark     = MARK_EMPTY;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(TABLE_DEPTH - 1) && clr_emit_r) begin
          live_nxt       = '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_CLEARED;
          out_handle_nxt = '0;
          out_pos_nxt    = '0;
          out_probes_nxt = '0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          tomb_seen_nxt = 1'b0;
          n_nxt         = NPROBE_W'(1);
          if (in_req_type == REQ_CLEAR) begin
            clr_cnt_nxt  = '0;
            clr_emit_nxt = 1'b1;
          end else if (in_req_type == REQ_FIND || in_req_type == REQ_DEL) begin
            mod_start = 1'b1;
            mod_value = HASH_W'(in_high_ref >> 2) + (HASH_W'(in_low_ref) << 1);
          end else begin
            // unknown request: answer at once, nothing changes
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_handle_nxt = '0;
            out_pos_nxt    = '0;
            out_probes_nxt = '0;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          pos_nxt   = mod_rem;
          mod_start = 1'b1;
          mod_value = HASH_W'(key_r.high) + (HASH_W'(key_r.low) << 1);
        end
      end
      S_STEP: begin
        if (mod_done) step_nxt = mod_rem;
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_CHK: begin
        if (req_r == REQ_FIND) begin
          if (rd_mark == MARK_TOMB && !tomb_seen_r) begin
            tomb_seen_nxt = 1'b1;
            tomb_nxt      = pos_r;
          end
          if (rd_mark == MARK_EMPTY) begin
            // insert into first tombstone passed, else here
            wr.mark_en     = 1'b1;
            wr.data_en     = 1'b1;
            wr.addr        = tomb_seen_r ? tomb_r : pos_r;
            wr.mark        = MARK_LIVE;
            live_nxt       = live_r + 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_INSERTED;
            out_handle_nxt = key_r.handle;
            out_pos_nxt    = wr.addr;
            out_probes_nxt = n_r;
          end else if (key_hit) begin
            // on a tombstone passed, move the match into it
            wr.mark_en     = tomb_seen_r;
            wr.data_en     = tomb_seen_r;
            wr.addr        = tomb_r;
            wr.mark        = MARK_LIVE;
            wr_data.handle = rd_data.handle;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FOUND;
            out_handle_nxt = rd_data.handle;
            out_pos_nxt    = tomb_seen_r ? tomb_r : pos_r;
            out_probes_nxt = n_r;
          end else if (n_r >= limit) begin
            out_valid_nxt  = 1'b1;
            out_probes_nxt = limit;
            if (tomb_seen_nxt) begin
              wr.mark_en     = 1'b1;
              wr.data_en     = 1'b1;
              wr.addr        = tomb_nxt;
              wr.mark        = MARK_LIVE;
              live_nxt       = live_r + 1'b1;
              out_status_nxt = ST_INSERTED;
              out_handle_nxt = key_r.handle;
              out_pos_nxt    = tomb_nxt;
            end else begin
              out_status_nxt = ST_FULL;
              out_handle_nxt = '0;
              out_pos_nxt    = '0;
            end
          end else begin
            n_nxt     = n_r + 1'b1;
            mod_start = 1'b1;
            mod_short = 1'b1;
            mod_value = HASH_W'(probe_sum);
          end
        end else begin
          if (rd_mark == MARK_EMPTY) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_handle_nxt = '0;
            out_pos_nxt    = '0;
            out_probes_nxt = n_r;
          end else if (key_hit) begin
            wr.mark_en     = 1'b1;
            wr.mark        = MARK_TOMB;
            if (live_r != '0) live_nxt = live_r - 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DELETED;
            out_handle_nxt = rd_data.handle;
            out_pos_nxt    = pos_r;
            out_probes_nxt = n_r;
          end else if (n_r >= limit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_handle_nxt = '0;
            out_pos_nxt    = '0;
            out_probes_nxt = limit;
          end else begin
            n_nxt     = n_r + 1'b1;
            mod_start = 1'b1;
            mod_short = 1'b1;
            mod_value = HASH_W'(probe_sum);
          end
        end
      end
      S_NEXT: begin
        if (mod_done) pos_nxt = mod_rem;
      end
      S_WTOMB: begin
        // old slot of a moved match becomes a tombstone
        wr.mark_en = 1'b1;
        wr.mark    = MARK_TOMB;
      end
      default: ;
    endcase
  end

  // Control registers; reset starts the mark sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_emit_r  <= 1'b0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      size_r      <= SIZE_W'(4093);
      scan_r      <= SCAN_W'(16);
      tomb_seen_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_emit_r  <= (state_r == S_CLEAR && state_nxt == S_IDLE) ? 1'b0 : clr_emit_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      tomb_seen_r <= tomb_seen_nxt;
      n_r         <= n_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TABLE_SIZE) begin
          size_r <= cfg_data;
        end else begin
          scan_r <= cfg_data[SCAN_W-1:0];
        end
      end
    end
  end

  // Payload registers: hold the request key and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r         <= in_req_type;
      key_r.nvar    <= in_node_var;
      key_r.high    <= in_high_ref;
      key_r.low     <= in_low_ref;
      key_r.handle  <= in_node_handle;
    end
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    tomb_r       <= tomb_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_pos_r    <= out_pos_nxt;
    out_probes_r <= out_probes_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;
  assign out_slot_pos      = out_pos_r;
  assign out_live_count    = live_r;
  assign out_probes_used   = out_probes_r;

endmodule

// File: bench/nuht_checker.sv
`default_nettype none

// Scoreboard for the unique table: mirrors the slot store, predicts each
// request's result at the request transfer and compares it with the result pulse.
module nuht_checker import nuht_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [VAR_W-1:0]    in_node_var,
  input  wire logic [HANDLE_W-1:0] in_high_ref,
  input  wire logic [HANDLE_W-1:0] in_low_ref,
  input  wire logic [HANDLE_W-1:0] in_node_handle,
  input  wire logic                out_valid,
  input  wire logic [STATUS_W-1:0] out_status,
  input  wire logic [HANDLE_W-1:0] out_result_handle,
  input  wire logic [ADDR_W-1:0]   out_slot_pos,
  input  wire logic [SIZE_W-1:0]   out_live_count,
  input  wire logic [NPROBE_W-1:0] out_probes_used,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [SIZE_W-1:0]   cfg_data,
  output int                       fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   pos;
    logic [SIZE_W-1:0]   live;
    logic [NPROBE_W-1:0] probes;
  } lookup_result_t;

  mark_t               mark_q   [TABLE_DEPTH];
  logic [VAR_W-1:0]    var_q    [TABLE_DEPTH];
  logic [HANDLE_W-1:0] high_q   [TABLE_DEPTH];
  logic [HANDLE_W-1:0] low_q    [TABLE_DEPTH];
  logic [HANDLE_W-1:0] handle_q [TABLE_DEPTH];
  logic [SIZE_W-1:0]   live_q;
  logic [SIZE_W-1:0]   size_reg;
  logic [SCAN_W-1:0]   scan_reg;
  lookup_result_t      pending_results[$];

  function automatic bit key_hit(int p, logic [VAR_W-1:0] v, logic [HANDLE_W-1:0] h,
                                 logic [HANDLE_W-1:0] l);
    return mark_q[p] == MARK_LIVE && var_q[p] == v && high_q[p] == h && low_q[p] == l;
  endfunction

  function automatic void store_key(int p, logic [VAR_W-1:0] v, logic [HANDLE_W-1:0] h,
                                    logic [HANDLE_W-1:0] l, logic [HANDLE_W-1:0] hd);
    mark_q[p]   = MARK_LIVE;
    var_q[p]    = v;
    high_q[p]   = h;
    low_q[p]    = l;
    handle_q[p] = hd;
  endfunction

  // Walk the probe chain and update the mirrored store.
  function automatic lookup_result_t lookup_update(logic [1:0] req, logic [VAR_W-1:0] v,
      logic [HANDLE_W-1:0] h, logic [HANDLE_W-1:0] l, logic [HANDLE_W-1:0] hd);
    lookup_result_t r;
    longint unsigned modulus;
    longint unsigned pos;
    longint unsigned limit;
    longint unsigned n;
    bit tomb_seen;
    int tomb;
    r = '0;
    tomb_seen = 0;
    tomb = 0;
    modulus = (size_reg == 0) ? 1 : (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg;
    pos = ((longint'(h) >> 2) + (longint'(l) << 1)) % modulus;
    limit = longint'(scan_reg) + 1;
    r.status = ST_MISS;
    if (req == REQ_FIND) begin
      for (n = 1; n <= limit; n++) begin
        if (mark_q[pos] == MARK_TOMB) begin
          if (!tomb_seen) begin
            tomb_seen = 1;
            tomb = int'(pos);
          end
        end else if (mark_q[pos] == MARK_EMPTY) begin
          store_key(tomb_seen ? tomb : int'(pos), v, h, l, hd);
          live_q++;
          r.status = ST_INSERTED;
          r.handle = hd;
          r.pos = ADDR_W'(tomb_seen ? tomb : int'(pos));
          r.probes = NPROBE_W'(n);
          r.live = live_q;
          return r;
        end else if (key_hit(int'(pos), v, h, l)) begin
          r.status = ST_FOUND;
          r.handle = handle_q[pos];
          r.pos = ADDR_W'(pos);
          if (tomb_seen) begin
            // move the match forward into the first tombstone
            store_key(tomb, v, h, l, handle_q[pos]);
            mark_q[pos] = MARK_TOMB;
            r.pos = ADDR_W'(tomb);
          end
          r.probes = NPROBE_W'(n);
          r.live = live_q;
          return r;
        end
        pos = (5 * pos + longint'(h) + (longint'(l) << 1)) % modulus;
      end
      r.probes = NPROBE_W'(limit);
      if (tomb_seen) begin
        store_key(tomb, v, h, l, hd);
        live_q++;
        r.status = ST_INSERTED;
        r.handle = hd;
        r.pos = ADDR_W'(tomb);
      end else begin
        r.status = ST_FULL;
      end
    end else if (req == REQ_DEL) begin
      r.probes = NPROBE_W'(limit);
      for (n = 1; n <= limit; n++) begin
        if (mark_q[pos] == MARK_EMPTY) begin
          r.probes = NPROBE_W'(n);
          break;
        end
        if (key_hit(int'(pos), v, h, l)) begin
          mark_q[pos] = MARK_TOMB;
          if (live_q > 0) live_q--;
          r.status = ST_DELETED;
          r.handle = handle_q[pos];
          r.pos = ADDR_W'(pos);
          r.probes = NPROBE_W'(n);
          break;
        end
        pos = (5 * pos + longint'(h) + (longint'(l) << 1)) % modulus;
      end
    end else if (req == REQ_CLEAR) begin
      foreach (mark_q[i]) mark_q[i] = MARK_EMPTY;
      live_q = '0;
      r.status = ST_CLEARED;
    end
    r.live = live_q;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (!rst_n) begin
      foreach (mark_q[i]) mark_q[i] = MARK_EMPTY;
      live_q = '0;
      size_reg = 13'd4093;
      scan_reg = 8'd16;
      pending_results.delete();
      fail_count = 0;
    end else begin
      // compare first: a result in this cycle belongs to an older request
      if (out_valid) begin
        got = '{out_status, out_result_handle, out_slot_pos, out_live_count,
                out_probes_used};
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result status=%0d handle=%h", $realtime, out_status,
                   out_result_handle);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got != want) begin
            $display("%0t expected st=%0d hd=%h pos=%0d live=%0d probes=%0d", $realtime,
                     want.status, want.handle, want.pos, want.live, want.probes);
            $display("%0t actual   st=%0d hd=%h pos=%0d live=%0d probes=%0d", $realtime,
                     got.status, got.handle, got.pos, got.live, got.probes);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(lookup_update(in_req_type, in_node_var, in_high_ref,
                                                in_low_ref, in_node_handle));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TABLE_SIZE) size_reg = cfg_data;
        else scan_reg = cfg_data[SCAN_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: bench/node_unique_hash_table_test.sv
`default_nettype none

// Stimulus and verdict for the unique table. Result checking lives in the
// scoreboard instance; this module drives requests, register writes and a stall watchdog.
module node_unique_hash_table_test;
  import nuht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 50000;
  localparam int KEY_POOL    = 24;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_req_type = REQ_FIND;
  logic [VAR_W-1:0]    in_node_var = '0;
  logic [HANDLE_W-1:0] in_high_ref = '0;
  logic [HANDLE_W-1:0] in_low_ref = '0;
  logic [HANDLE_W-1:0] in_node_handle = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_result_handle;
  logic [ADDR_W-1:0]   out_slot_pos;
  logic [SIZE_W-1:0]   out_live_count;
  logic [NPROBE_W-1:0] out_probes_used;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = CFG_TABLE_SIZE;
  logic [SIZE_W-1:0]   cfg_data = '0;

  int fail_count;
  int requests_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int idle_mode = 0;  // 0 none, 1 sender 73%, 2 sender 14%

  logic [VAR_W-1:0]    pool_var  [KEY_POOL];
  logic [HANDLE_W-1:0] pool_high [KEY_POOL];
  logic [HANDLE_W-1:0] pool_low  [KEY_POOL];

  always #4 clk = ~clk;

  node_unique_hash_table u_top (.*);

  nuht_checker u_check (.*);

  // Count result pulses and watch for a stuck block.
  always @(posedge clk) begin
    if (out_valid) results_seen++;
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("node_unique_hash_table: mismatch");
      $finish;
    end
  end

  // Hold until every request has its result and the block is idle again.
  task automatic drain();
    while (results_seen != requests_sent || busy) @(negedge clk);
  endtask

  task automatic send_request(logic [1:0] req, logic [VAR_W-1:0] v, logic [HANDLE_W-1:0] h,
                              logic [HANDLE_W-1:0] l, logic [HANDLE_W-1:0] hd);
    // random sender gaps, per the current phase
    if (idle_mode == 1)
      while ($urandom_range(99) < 73) @(negedge clk);
    else if (idle_mode == 2)
      while ($urandom_range(99) < 14) @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    in_req_type = req;
    in_node_var = v;
    in_high_ref = h;
    in_low_ref = l;
    in_node_handle = hd;
    @(negedge clk);
    start = 1'b0;
    requests_sent++;
  endtask

  task automatic write_reg(logic idx, logic [SIZE_W-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_table(logic [SIZE_W-1:0] size, logic [SCAN_W-1:0] scan);
    write_reg(CFG_TABLE_SIZE, size);
    write_reg(CFG_MAX_SCAN, {{(SIZE_W-SCAN_W){1'b0}}, scan});
  endtask

  // Mostly keys from a small pool so finds, moves and deletes hit live slots.
  task automatic random_request();
    int k;
    int r;
    logic [1:0] req;
    k = $urandom_range(KEY_POOL - 1);
    r = $urandom_range(99);
    if ($urandom_range(99) < 8) begin
      pool_var[k] = VAR_W'($urandom);
      pool_high[k] = $urandom;
      pool_low[k] = $urandom;
    end
    if (r < 3) req = REQ_CLEAR;
    else if (r < 6) req = REQ_UNKNOWN;
    else if (r < 62) req = REQ_FIND;
    else req = REQ_DEL;
    if ($urandom_range(99) < 80)
      send_request(req, pool_var[k], pool_high[k], pool_low[k], $urandom);
    else
      send_request(req, VAR_W'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic run_phase(logic [SIZE_W-1:0] size, logic [SCAN_W-1:0] scan, int count,
                           int mode);
    set_table(size, scan);
    idle_mode = mode;
    for (int i = 0; i < count; i++) begin
      random_request();
      // in phases without idle gaps, let the pipe run dry once mid-phase
      if (i == count / 2 && mode == 0) drain();
    end
  endtask

  initial begin
    foreach (pool_var[i]) begin
      pool_var[i] = VAR_W'($urandom);
      pool_high[i] = $urandom;
      pool_low[i] = $urandom;
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: a five-slot table with short scans to hit every outcome.
    set_table(13'd5, 8'd2);
    send_request(REQ_CLEAR, '0, '0, '0, '0);
    send_request(REQ_FIND, '0, '0, '0, '0);
    send_request(REQ_FIND, '1, '1, '1, '1);
    send_request(REQ_FIND, '0, '0, '0, 32'h1234_5678);       // found
    send_request(REQ_FIND, 16'h0001, 32'h4, 32'h0, 32'hA);
    send_request(REQ_FIND, 16'h0002, 32'h8, 32'h1, 32'hB);
    send_request(REQ_FIND, 16'h0003, 32'hC, 32'h2, 32'hC);
    send_request(REQ_FIND, 16'h0004, 32'h10, 32'h3, 32'hD);  // likely full
    send_request(REQ_DEL, '0, '0, '0, '0);                   // leave a tombstone
    send_request(REQ_DEL, '0, '0, '0, '0);                   // delete miss
    send_request(REQ_FIND, 16'h0005, 32'h14, 32'h0, 32'hE);  // reuse tombstone
    send_request(REQ_DEL, '1, '1, '1, '1);
    send_request(REQ_FIND, 16'h0001, 32'h4, 32'h0, 32'hF);   // may move forward
    send_request(REQ_FIND, 16'h0003, 32'hC, 32'h2, 32'h0);
    send_request(REQ_UNKNOWN, '1, '1, '1, '1);               // unknown request
    send_request(REQ_CLEAR, '1, '1, '1, '1);
    // size zero acts as one slot, no extra probes
    set_table(13'd0, 8'd0);
    send_request(REQ_FIND, 16'h00AA, 32'h0, 32'h0, 32'h55);
    send_request(REQ_FIND, 16'h00BB, 32'h0, 32'h0, 32'h66);  // full
    send_request(REQ_DEL, 16'h00BB, 32'h0, 32'h0, 32'h0);
    send_request(REQ_DEL, 16'h00AA, 32'h0, 32'h0, 32'h0);
    send_request(REQ_FIND, 16'h00BB, 32'h0, 32'h0, 32'h66);  // into tombstone at limit
    send_request(REQ_CLEAR, '0, '0, '0, '0);

    // Random phases sweep sizes, scan limits and idle patterns.
    run_phase(13'd4093, 8'd16, 150, 0);
    run_phase(13'd7, 8'd3, 200, 1);
    run_phase(13'd1, 8'd0, 60, 2);
    run_phase(13'd8191, 8'd255, 120, 2);
    run_phase(13'd13, 8'd255, 40, 0);
    run_phase(13'd31, 8'd8, 200, 1);
    run_phase(13'd4096, 8'd0, 100, 0);
    run_phase(13'd61, 8'd5, 190, 2);

    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("node_unique_hash_table: match");
    else
      $display("node_unique_hash_table: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
